@@ rtl/ajb_pkg.sv @@
`default_nettype none
package ajb_pkg;

  localparam int SLOTS_DEF          = 8;
  localparam int PKT_LEN_DEF        = 64;
  localparam int TRAIL_SAMPLES_DEF  = 16;
  localparam int SAMPLE_BITS_DEF    = 24;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_OLDER     = 3'd1;
  localparam logic [2:0] ST_REPEATED  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_PLAYING   = 3'd4;
  localparam logic [2:0] ST_REPEATING = 3'd5;
  localparam logic [2:0] ST_WAITING   = 3'd6;

  localparam logic CFG_CORRECTION = 1'b0;
  localparam logic CFG_REPEAT     = 1'b1;

  localparam logic [7:0] REPEAT_RESET = 8'd5;

  typedef enum logic [2:0] {
    MODE_WAIT   = 3'b001,
    MODE_PLAY   = 3'b010,
    MODE_REPEAT = 3'b100
  } mode_t;

  // Result fields that ride along the sample datapath.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] number;
    logic        last;
  } meta_t;

  // How the datapath forms the sample of one item.
  typedef struct packed {
    logic keep2;  // use the source slot sample, else zero
    logic use1;   // crossfade from the trailing sample
    logic s1ok;   // trailing sample is readable: written, or not in slot zero
  } xf_ctl_t;

endpackage
`default_nettype wire

@@ rtl/audio_jitter_buffer_concealment_core.sv @@
`default_nettype none
// Stereo jitter buffer with gap concealment. Every item, packet sample or play
// request, returns one result item; one item is accepted each cycle unless the
// output stalls. Results leave in order through the memory read, the crossfade
// difference, the position product, the reciprocal division by the trail
// length and the output register. The whole pipeline halts while the output
// holds a stalled result, so the input stalls in exactly those cycles. Samples
// live in one dual-read-port memory of SLOTS*(PKT_LEN+TRAIL_SAMPLES) entries;
// the play path reads the source sample and the trailing sample of the current
// slot in the same cycle. The trailing samples of slot zero read as zero until
// written. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while the block is idle, as the block does not enforce it.
module audio_jitter_buffer_concealment_core #(
  parameter int SLOTS          = ajb_pkg::SLOTS_DEF,
  parameter int PKT_LEN        = ajb_pkg::PKT_LEN_DEF,
  parameter int TRAIL_SAMPLES  = ajb_pkg::TRAIL_SAMPLES_DEF,
  parameter int SAMPLE_BITS    = ajb_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [31:0] in_packet_number,
  input  wire logic [6:0]  in_sample_index,
  input  wire logic [23:0] in_in_left,
  input  wire logic [23:0] in_in_right,
  input  wire logic        in_packet_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_played_number,
  output logic [23:0]      out_out_left,
  output logic [23:0]      out_out_right,
  output logic             out_out_last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import ajb_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int STRIDE = PKT_LEN + TRAIL_SAMPLES;
  localparam int DEPTH  = SLOTS * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(SLOTS);
  localparam int PW     = $clog2(PKT_LEN);
  localparam int TW     = (TRAIL_SAMPLES > 1) ? $clog2(TRAIL_SAMPLES) : 1;
  localparam int XF_LEN = (TRAIL_SAMPLES < PKT_LEN) ? TRAIL_SAMPLES : PKT_LEN;

  function automatic logic [SB-1:0] to_samp(input logic [23:0] v);
    logic signed [23:0] vs;
    logic [31:0]        w;
    vs = v;
    w  = 32'(vs);
    return w[SB-1:0];
  endfunction

  function automatic logic [23:0] to24(input logic [SB-1:0] s);
    logic signed [SB-1:0] ss;
    logic [31:0]          w;
    ss = s;
    w  = 32'(ss);
    return w[23:0];
  endfunction

  // Configuration.
  logic       corr_en_r;
  logic [7:0] rep_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_en_r   <= 1'b1;
      rep_limit_r <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORRECTION: corr_en_r   <= cfg_data[0];
        CFG_REPEAT:     rep_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Buffer state.
  logic [SW-1:0]  read_slot_r, read_slot_nxt;
  logic [SW-1:0]  write_slot_r, write_slot_nxt;
  logic [31:0]    newest_r, newest_nxt;
  logic [7:0]     rep_left_r, rep_left_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  mode_t          mode_r, mode_nxt;
  logic [SW-1:0]  src_slot_r, src_slot_nxt;
  logic [31:0]    src_num_r, src_num_nxt;
  logic [31:0]    read_num_r, read_num_nxt;
  logic           xf_r, xf_nxt;
  logic           pacc_r, pacc_nxt;
  logic [2:0]     pkt_status_r, pkt_status_nxt;
  logic [31:0]    pkt_number_r, pkt_number_nxt;
  logic [31:0]    slot_num_r [SLOTS];
  logic [TRAIL_SAMPLES-1:0] trail_ok_r, trail_ok_nxt;

  logic           en, acc;
  logic           slot_we;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, raddr_trail, raddr_src;
  logic [SW-1:0]  next_slot;
  logic [31:0]    waddr32, ra1_32, ra2_32, idx32, p32, tofs32;
  meta_t          imeta;
  xf_ctl_t        ictl;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign next_slot = (read_slot_r == SW'(SLOTS - 1)) ? '0 : read_slot_r + 1'b1;
  assign idx32     = 32'(in_sample_index);
  assign tofs32    = idx32 - 32'(PKT_LEN);
  assign p32       = 32'(pos_r);
  assign waddr32   = 32'(write_slot_r) * STRIDE + idx32;
  assign ram_waddr = waddr32[AW-1:0];

  always_comb begin
    read_slot_nxt  = read_slot_r;
    write_slot_nxt = write_slot_r;
    newest_nxt     = newest_r;
    rep_left_nxt   = rep_left_r;
    pos_nxt        = pos_r;
    mode_nxt       = mode_r;
    src_slot_nxt   = src_slot_r;
    src_num_nxt    = src_num_r;
    read_num_nxt   = read_num_r;
    xf_nxt         = xf_r;
    pacc_nxt       = pacc_r;
    pkt_status_nxt = pkt_status_r;
    pkt_number_nxt = pkt_number_r;
    trail_ok_nxt   = trail_ok_r;
    slot_we        = 1'b0;
    ram_we         = 1'b0;
    imeta          = '0;
    ictl           = '0;
    ra1_32         = '0;
    ra2_32         = '0;

    if (acc && !in_command) begin
      if (in_sample_index == '0) begin
        pacc_nxt       = 1'b0;
        pkt_number_nxt = in_packet_number;
        if (in_packet_number < newest_r) begin
          pkt_status_nxt = ST_OLDER;
        end else if (in_packet_number == newest_r) begin
          pkt_status_nxt = ST_REPEATED;
        end else if (write_slot_r == read_slot_r) begin
          pkt_status_nxt = ST_FULL;
        end else begin
          pkt_status_nxt = ST_ACCEPTED;
          newest_nxt     = in_packet_number;
          slot_we        = 1'b1;
          pacc_nxt       = 1'b1;
        end
      end
      if (pacc_nxt) begin
        if (idx32 < STRIDE) begin
          ram_we = 1'b1;
          if (write_slot_r == '0 && idx32 >= PKT_LEN) begin
            trail_ok_nxt[tofs32[TW-1:0]] = 1'b1;
          end
        end
        if (in_packet_end) begin
          write_slot_nxt = (write_slot_r == SW'(SLOTS - 1)) ? '0 : write_slot_r + 1'b1;
          pacc_nxt       = 1'b0;
        end
      end
      imeta.status = pkt_status_nxt;
      imeta.number = pkt_number_nxt;
    end

    if (acc && in_command) begin
      if (pos_r == '0) begin
        // New output packet: advance, repeat or go silent.
        if (write_slot_r != next_slot) begin
          mode_nxt     = MODE_PLAY;
          rep_left_nxt = rep_limit_r;
          src_slot_nxt = next_slot;
          src_num_nxt  = slot_num_r[next_slot];
        end else if (rep_left_r != '0) begin
          rep_left_nxt = rep_left_r - 1'b1;
          mode_nxt     = MODE_REPEAT;
          src_slot_nxt = read_slot_r;
          src_num_nxt  = read_num_r;
        end else begin
          mode_nxt     = MODE_WAIT;
          src_slot_nxt = read_slot_r;
          src_num_nxt  = read_num_r;
        end
        xf_nxt = corr_en_r && (src_num_nxt != read_num_r + 32'd1);
      end

      ra2_32     = 32'(src_slot_nxt) * STRIDE + p32;
      ra1_32     = 32'(read_slot_r) * STRIDE + PKT_LEN + p32;
      ictl.keep2 = (mode_nxt != MODE_WAIT);
      ictl.use1  = ictl.keep2 && xf_nxt && (p32 < XF_LEN);
      if (ictl.use1) begin
        ictl.s1ok = (read_slot_r != '0) || trail_ok_r[p32[TW-1:0]];
      end

      unique case (mode_nxt)
        MODE_PLAY:   imeta.status = ST_PLAYING;
        MODE_REPEAT: imeta.status = ST_REPEATING;
        default:     imeta.status = ST_WAITING;
      endcase
      imeta.number = (mode_nxt == MODE_WAIT) ? '0 : src_num_nxt;
      imeta.last   = (p32 == PKT_LEN - 1);

      if (p32 == PKT_LEN - 1) begin
        pos_nxt = '0;
        if (mode_nxt == MODE_PLAY) begin
          read_slot_nxt = src_slot_nxt;
          read_num_nxt  = src_num_nxt;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  assign raddr_trail = ra1_32[AW-1:0];
  assign raddr_src   = ra2_32[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_slot_r  <= '0;
      write_slot_r <= SW'(1);
      newest_r     <= '0;
      rep_left_r   <= '0;
      pos_r        <= '0;
      mode_r       <= MODE_WAIT;
      src_slot_r   <= '0;
      src_num_r    <= '0;
      read_num_r   <= '0;
      xf_r         <= 1'b0;
      pacc_r       <= 1'b0;
      pkt_status_r <= ST_REPEATED;
      pkt_number_r <= '0;
      trail_ok_r   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_num_r[i] <= '0;
      end
    end else begin
      read_slot_r  <= read_slot_nxt;
      write_slot_r <= write_slot_nxt;
      newest_r     <= newest_nxt;
      rep_left_r   <= rep_left_nxt;
      pos_r        <= pos_nxt;
      mode_r       <= mode_nxt;
      src_slot_r   <= src_slot_nxt;
      src_num_r    <= src_num_nxt;
      read_num_r   <= read_num_nxt;
      xf_r         <= xf_nxt;
      pacc_r       <= pacc_nxt;
      pkt_status_r <= pkt_status_nxt;
      pkt_number_r <= pkt_number_nxt;
      trail_ok_r   <= trail_ok_nxt;
      if (slot_we) begin
        slot_num_r[write_slot_r] <= in_packet_number;
      end
    end
  end

  logic [2*SB-1:0] rd_trail, rd_src;

  ajb_ram #(
    .WIDTH (2 * SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   ({to_samp(in_in_left), to_samp(in_in_right)}),
    .re      (acc && in_command),
    .raddr_a (raddr_trail),
    .raddr_b (raddr_src),
    .rdata_a (rd_trail),
    .rdata_b (rd_src)
  );

  logic          xv;
  meta_t         xmeta;
  logic [SB-1:0] xleft, xright;

  ajb_xfade #(
    .SAMPLE_BITS (SB),
    .PW          (PW),
    .TRAIL       (TRAIL_SAMPLES)
  ) u_xfade (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .iv       (acc),
    .imeta    (imeta),
    .ictl     (ictl),
    .ipos     (pos_r),
    .rd_trail (rd_trail),
    .rd_src   (rd_src),
    .ov       (xv),
    .ometa    (xmeta),
    .oleft    (xleft),
    .oright   (xright)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= xv;
    end
    if (en) begin
      out_status        <= xmeta.status;
      out_played_number <= xmeta.number;
      out_out_last      <= xmeta.last;
      out_out_left      <= to24(xleft);
      out_out_right     <= to24(xright);
    end
  end

  // A slot being played is never the one being filled.
  a_src_not_write: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0 && mode_r == MODE_PLAY) |-> (src_slot_r != write_slot_r))
    else $error("playing slot overlaps write slot");

  // An open packet never targets the slot being read.
  a_open_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    pacc_r |-> (write_slot_r != read_slot_r))
    else $error("accepted packet writes into read slot");

  // The last sample of an output packet wraps the position.
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_command && p32 == PKT_LEN - 1) |=> (pos_r == '0))
    else $error("output position did not wrap");

  // Repeat count only reloads on a new played slot.
  a_repeat_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (rep_left_r > $past(rep_left_r)) |-> (mode_r == MODE_PLAY))
    else $error("repeat counter grew without a new slot");

endmodule
`default_nettype wire

@@ rtl/ajb_ram.sv @@
`default_nettype none
module ajb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ajb_xfade.sv @@
`default_nettype none
module ajb_xfade #(
  parameter int SAMPLE_BITS = 24,
  parameter int PW          = 6,
  parameter int TRAIL       = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     iv,
  input  wire ajb_pkg::meta_t           imeta,
  input  wire ajb_pkg::xf_ctl_t         ictl,
  input  wire logic [PW-1:0]            ipos,
  input  wire logic [2*SAMPLE_BITS-1:0] rd_trail,
  input  wire logic [2*SAMPLE_BITS-1:0] rd_src,
  output logic                          ov,
  output ajb_pkg::meta_t                ometa,
  output logic [SAMPLE_BITS-1:0]        oleft,
  output logic [SAMPLE_BITS-1:0]        oright
);
  import ajb_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int MW  = SB + 1 + PW;
  // The magnitude of the product stays below 2^MW, so a reciprocal rounded up
  // with SH fraction bits gives the exact truncated quotient.
  localparam int LT  = $clog2(TRAIL);
  localparam int SH  = MW + LT;
  localparam int KW  = SH + 1;
  localparam int HW  = MW / 2;
  localparam int GW  = MW - HW;
  localparam int FW  = MW + KW;
  localparam logic [KW-1:0] RECIP =
    KW'(((64'd1 << SH) + 64'(TRAIL) - 64'd1) / 64'(TRAIL));

  // Stage A: memory data arrives.
  logic    a_v_r;
  meta_t   a_meta_r;
  xf_ctl_t a_ctl_r;
  logic [PW-1:0] a_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= iv;
    end
    if (en) begin
      a_meta_r <= imeta;
      a_ctl_r  <= ictl;
      a_p_r    <= ipos;
    end
  end

  // Stage B: pick the end points and form their difference.
  logic signed [SB-1:0] s1 [2];
  logic signed [SB-1:0] s2 [2];
  logic signed [SB:0]   dd [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      s2[c] = a_ctl_r.keep2 ? rd_src[(1-c)*SB +: SB] : '0;
      if (a_ctl_r.use1) begin
        s1[c] = a_ctl_r.s1ok ? rd_trail[(1-c)*SB +: SB] : '0;
        dd[c] = (SB+1)'(s2[c]) - (SB+1)'(s1[c]);
      end else begin
        s1[c] = s2[c];
        dd[c] = '0;
      end
    end
  end

  logic                 b_v_r;
  meta_t                b_meta_r;
  logic [PW-1:0]        b_p_r;
  logic signed [SB-1:0] b_s1_r [2];
  logic signed [SB:0]   b_d_r  [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_meta_r <= a_meta_r;
      b_p_r    <= a_p_r;
      for (int c = 0; c < 2; c++) begin
        b_s1_r[c] <= s1[c];
        b_d_r[c]  <= dd[c];
      end
    end
  end

  // Stage C: position times difference.
  logic                   c_v_r;
  meta_t                  c_meta_r;
  logic signed [SB-1:0]   c_s1_r   [2];
  logic signed [MW:0]     c_prod_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
    if (en) begin
      c_meta_r <= b_meta_r;
      for (int c = 0; c < 2; c++) begin
        c_s1_r[c]   <= b_s1_r[c];
        c_prod_r[c] <= $signed({1'b0, b_p_r}) * b_d_r[c];
      end
    end
  end

  // Stage D1: magnitude times the reciprocal, in two halves.
  logic [MW-1:0] mag [2];
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mag[c] = c_prod_r[c][MW] ? MW'(-c_prod_r[c]) : MW'(c_prod_r[c]);
    end
  end

  logic                 d1_v_r;
  meta_t                d1_meta_r;
  logic                 d1_neg_r [2];
  logic signed [SB-1:0] d1_s1_r  [2];
  logic [HW+KW-1:0]     d1_lo_r  [2];
  logic [GW+KW-1:0]     d1_hi_r  [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= c_v_r;
    end
    if (en) begin
      d1_meta_r <= c_meta_r;
      for (int c = 0; c < 2; c++) begin
        d1_neg_r[c] <= c_prod_r[c][MW];
        d1_s1_r[c]  <= c_s1_r[c];
        d1_lo_r[c]  <= (HW+KW)'(mag[c][HW-1:0]) * (HW+KW)'(RECIP);
        d1_hi_r[c]  <= (GW+KW)'(mag[c][MW-1:HW]) * (GW+KW)'(RECIP);
      end
    end
  end

  // Stage D2: combine the halves and keep the quotient.
  logic [FW-1:0] full [2];
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      full[c] = {d1_hi_r[c], {HW{1'b0}}} + FW'(d1_lo_r[c]);
    end
  end

  logic                 d2_v_r;
  meta_t                d2_meta_r;
  logic                 d2_neg_r [2];
  logic signed [SB-1:0] d2_s1_r  [2];
  logic [SB:0]          d2_q_r   [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else if (en) begin
      d2_v_r <= d1_v_r;
    end
    if (en) begin
      d2_meta_r <= d1_meta_r;
      for (int c = 0; c < 2; c++) begin
        d2_neg_r[c] <= d1_neg_r[c];
        d2_s1_r[c]  <= d1_s1_r[c];
        d2_q_r[c]   <= full[c][SH+SB:SH];
      end
    end
  end

  // Final add of the signed quotient to the start sample (trailing or source).
  logic signed [SB+1:0] q   [2];
  logic signed [SB+1:0] res [2];
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      q[c]   = $signed({1'b0, d2_q_r[c]});
      res[c] = (SB+2)'(d2_s1_r[c]) + (d2_neg_r[c] ? -q[c] : q[c]);
    end
  end

  assign ov     = d2_v_r;
  assign ometa  = d2_meta_r;
  assign oleft  = res[0][SB-1:0];
  assign oright = res[1][SB-1:0];

endmodule
`default_nettype wire
